// ===== rtl/core/cfpa_pkg.sv =====
// cfpa_pkg: shared types, codes and constants of the complex fixed point alu
// used by cfpa_divsqrt, complex_fixed_point_alu_unit and the testbench
`timescale 1ns / 1ps
`default_nettype none
package cfpa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EXP_BITS_DEF  = 8;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_POW  = 4'd4,
    CMD_MAG  = 4'd5,
    CMD_CONJ = 4'd6,
    CMD_NEG  = 4'd7,
    CMD_EQ   = 4'd8
  } cmd_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] first_re;
    logic signed [31:0] first_im;
    logic signed [31:0] second_re;
    logic signed [31:0] second_im;
    logic [7:0]         exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               equal_flag;
    logic               div_zero;
    logic               overflow;
  } out_item_t;

  // sign and magnitude form of a wide intermediate value
  typedef struct packed {
    logic        neg;
    logic [64:0] mag;
  } smag_t;

  // start request and operands for the long division / square root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [64:0] num;
    logic [63:0] den;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } ds_rsp_t;

  // saturate a sign and magnitude value to 32 bits, flagging overflow
  function automatic logic [32:0] settle(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag >= 65'h0_8000_0000) r = {(mag != 65'h0_8000_0000), 32'h8000_0000};
      else r = {1'b0, 32'(-mag[31:0])};
    end else begin
      if (mag > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  // signed sum of two sign and magnitude values
  function automatic smag_t sm_add(input smag_t a, input smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == '0) r.neg = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cfpa_divsqrt.sv =====
// cfpa_divsqrt: shared radix-2 restoring long divider and square root unit
// depends on cfpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfpa_divsqrt #(
  parameter int FRAC_BITS = cfpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfpa_pkg::ds_req_t req,
  output cfpa_pkg::ds_rsp_t      rsp
);
  import cfpa_pkg::*;

  // quotient needs 33 integer bits plus FRAC_BITS+1 fraction bits
  localparam int QBITS    = 34 + FRAC_BITS;
  localparam int DIV_STEPS = 65 + FRAC_BITS + 1;
  localparam int CW       = 7;

  logic            busy_r, busy_nxt;
  logic            sqrt_r, sqrt_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [64:0]     num_r, num_nxt;
  logic [65:0]     rem_r, rem_nxt;
  logic [64:0]     den_r, den_nxt;
  logic [QBITS+31:0] q_r, q_nxt;
  logic [63:0]     res_r, res_nxt;
  logic            done_r, done_nxt;

  logic [65:0]     trial;
  logic [65:0]     rsh;
  logic [65:0]     sq_trial;
  logic [QBITS+31:0] qfin;

  always_comb begin
    busy_nxt = busy_r;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    rsh      = '0;
    trial    = '0;
    sq_trial = '0;
    qfin     = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      num_nxt  = req.num;
      den_nxt  = {1'b0, req.den};
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = req.is_sqrt ? CW'(32) : CW'(DIV_STEPS);
    end else if (busy_r) begin
      if (sqrt_r) begin
        // digit by digit square root, two radicand bits per step
        rsh      = {rem_r[63:0], num_r[63:62]};
        sq_trial = {q_r[63:0], 2'b01};
        num_nxt  = {num_r[62:0], 2'b00};
        if (rsh >= sq_trial) begin
          rem_nxt = rsh - sq_trial;
          q_nxt   = {q_r[QBITS+30:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          q_nxt   = {q_r[QBITS+30:0], 1'b0};
        end
      end else begin
        // shift in numerator bits, then FRAC_BITS+1 zeros
        rsh     = {rem_r[64:0], num_r[64]};
        num_nxt = {num_r[63:0], 1'b0};
        trial   = rsh - {1'b0, den_r};
        if (rsh >= {1'b0, den_r}) begin
          rem_nxt = trial;
          q_nxt   = {q_r[QBITS+30:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          q_nxt   = {q_r[QBITS+30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (sqrt_r) begin
          res_nxt = 64'(q_nxt[31:0]);
        end else begin
          qfin = q_nxt;
          // integer part at or above 2^33 saturates
          if (qfin[QBITS+31:FRAC_BITS+1+33] != '0) res_nxt = '1;
          else res_nxt = 64'((qfin + 1'b1) >> 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sqrt_r <= sqrt_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divsqrt done held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divsqrt restarted while busy");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divsqrt count ran out");

endmodule
`default_nettype wire

// ===== rtl/core/complex_fixed_point_alu_unit.sv =====
// complex_fixed_point_alu_unit: top level of the q16.16 complex alu
// depends on cfpa_pkg and cfpa_divsqrt
//
//  channel | ports                      | payload
//  input   | in_valid / in_ready        | in_data  (cfpa_pkg::in_item_t)
//  result  | out_valid / out_ready      | out_data (cfpa_pkg::out_item_t)
//
// add, sub, conjugate, negate, compare and unused codes go straight to the result; multiply,
// power (exponent-1 complex multiply steps, none for exponent 0 or 1), divide (no division
// for a zero divisor) and magnitude pass through the shared units: one 32x32 multiplier and
// one divide/sqrt unit are shared
// one item at a time: in_ready only in idle, in the cycle after the result transfer
// result held in out_data until taken; synchronous active low reset clears the sequencer
`timescale 1ns / 1ps
`default_nettype none
module complex_fixed_point_alu_unit #(
  parameter int FRAC_BITS = cfpa_pkg::FRAC_BITS_DEF,
  parameter int EXP_BITS  = cfpa_pkg::EXP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cfpa_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfpa_pkg::out_item_t     out_data
);
  import cfpa_pkg::*;

  // exponent bits in use, never more than the field carries
  localparam int EXP_W = (EXP_BITS < 8) ? EXP_BITS : 8;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,   // products through the shared multiplier: four for mul/pow, six for div, two for mag
    ST_COMB = 7'b0000100,   // combine products into re/im, or start the divider or square root
    ST_DIV  = 7'b0001000,   // long division, re then im
    ST_SQRT = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_FIN  = 7'b1000000    // pick results, drop into output register
  } state_t;

  state_t state_r, state_nxt;

  in_item_t          op_r;
  logic [3:0]        cmd_r;
  logic signed [31:0] pa_r, pb_r;          // running product for power
  logic signed [31:0] pa_nxt, pb_nxt;
  logic [EXP_W-1:0]  steps_r, steps_nxt;
  logic [2:0]        mi_r, mi_nxt;          // multiplier pass index
  smag_t             prod_r [4];            // ac, bd, ad, bc
  logic signed [63:0] mul_r;
  logic              mul_v_r;
  logic              ov_r, ov_nxt;
  logic              dz_r, dz_nxt;
  logic              dpart_r, dpart_nxt;    // 0 real part, 1 imaginary part
  logic signed [31:0] rre_r, rre_nxt, rim_r, rim_nxt;
  smag_t             nr_r, ni_r, nr_nxt, ni_nxt;
  logic [63:0]       den_r;
  out_item_t         out_r, out_nxt;
  logic              ov_valid_r, ov_valid_nxt;

  logic signed [31:0] mx, my;
  logic              in_xfer, out_xfer;
  ds_req_t           ds_req;
  ds_rsp_t           ds_rsp;
  smag_t             sre, sim, sa, sq_b;
  logic [32:0]       st_re, st_im;
  logic [64:0]       rq_re, rq_im;
  logic [32:0]       sat_a, sat_b;
  logic signed [32:0] wa, wb;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (state_r == ST_IDLE) && !ov_valid_r;
  assign out_valid = ov_valid_r;
  assign out_data  = out_r;

  cfpa_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  // shared multiplier operands: power uses the running product as c,d
  always_comb begin
    case (mi_r)
      3'd0: begin mx = op_r.first_re; my = (cmd_r == CMD_POW) ? pa_r : op_r.second_re; end
      3'd1: begin mx = op_r.first_im; my = (cmd_r == CMD_POW) ? pb_r : op_r.second_im; end
      3'd2: begin mx = op_r.first_re; my = (cmd_r == CMD_POW) ? pb_r : op_r.second_im; end
      3'd3: begin mx = op_r.first_im; my = (cmd_r == CMD_POW) ? pa_r : op_r.second_re; end
      3'd4: begin mx = op_r.second_re; my = op_r.second_re; end
      3'd5: begin mx = op_r.second_im; my = op_r.second_im; end
      3'd7: begin mx = op_r.first_im; my = op_r.first_im; end
      default: begin mx = op_r.first_re; my = op_r.first_re; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(mx) * 64'(my);
  end

  function automatic smag_t to_sm(input logic signed [63:0] p);
    smag_t r;
    r.neg = p[63];
    r.mag = p[63] ? 65'(-p) : 65'(p);
    return r;
  endfunction

  function automatic smag_t sm_neg(input smag_t a);
    smag_t r;
    r = a;
    if (a.mag != '0) r.neg = !a.neg;
    return r;
  endfunction

  always_comb begin
    state_nxt    = state_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    steps_nxt    = steps_r;
    mi_nxt       = mi_r;
    ov_nxt       = ov_r;
    dz_nxt       = dz_r;
    dpart_nxt    = dpart_r;
    rre_nxt      = rre_r;
    rim_nxt      = rim_r;
    nr_nxt       = nr_r;
    ni_nxt       = ni_r;
    out_nxt      = out_r;
    ov_valid_nxt = ov_valid_r;
    ds_req       = '0;
    sre = sm_add(prod_r[0], sm_neg(prod_r[1]));
    sim = sm_add(prod_r[2], prod_r[3]);
    sa  = '0;
    sq_b = to_sm(mul_r);
    rq_re = (sre.mag + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    rq_im = (sim.mag + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    st_re = settle(sre.neg, rq_re);
    st_im = settle(sim.neg, rq_im);
    wa = '0;
    wb = '0;
    sat_a = '0;
    sat_b = '0;

    if (out_xfer) ov_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ov_nxt  = 1'b0;
          dz_nxt  = 1'b0;
          rre_nxt = '0;
          rim_nxt = '0;
          mi_nxt  = '0;
          dpart_nxt = 1'b0;
          pa_nxt  = in_data.first_re;
          pb_nxt  = in_data.first_im;
          steps_nxt = in_data.exponent[EXP_W-1:0];
          case (in_data.cmd)
            CMD_MUL, CMD_DIV: state_nxt = ST_MUL;
            CMD_POW: begin
              if (in_data.exponent[EXP_W-1:0] == '0) begin
                rre_nxt = 32'sd1 <<< FRAC_BITS;
                state_nxt = ST_FIN;
              end else if (in_data.exponent[EXP_W-1:0] == EXP_W'(1)) begin
                rre_nxt = in_data.first_re;
                rim_nxt = in_data.first_im;
                state_nxt = ST_FIN;
              end else begin
                steps_nxt = in_data.exponent[EXP_W-1:0] - EXP_W'(1);
                state_nxt = ST_MUL;
              end
            end
            CMD_MAG: begin
              mi_nxt = 3'd6;
              state_nxt = ST_MUL;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MUL: begin
        // product of pass mi_r appears in mul_r in the following cycle
        if (cmd_r == CMD_MAG) begin
          if (mi_r == 3'd7 && mul_v_r) state_nxt = ST_COMB;
          else mi_nxt = 3'd7;
        end else if (cmd_r == CMD_DIV) begin
          if (mi_r == 3'd6) state_nxt = ST_COMB;
          else mi_nxt = mi_r + 3'd1;
        end else begin
          if (mi_r == 3'd4) state_nxt = ST_COMB;
          else mi_nxt = mi_r + 3'd1;
        end
      end
      ST_COMB: begin
        if (cmd_r == CMD_MAG) begin
          // re^2 held in prod_r[0], im^2 still in the multiplier register
          ds_req.start   = 1'b1;
          ds_req.is_sqrt = 1'b1;
          ds_req.num     = prod_r[0].mag + sq_b.mag;
          state_nxt = ST_SQRT;
        end else if (cmd_r == CMD_DIV) begin
          // prod holds ac, bd, ad, bc; den_r holds c^2+d^2
          nr_nxt = sm_add(prod_r[0], prod_r[1]);
          ni_nxt = sm_add(prod_r[3], sm_neg(prod_r[2]));
          if (op_r.second_re == '0 && op_r.second_im == '0) begin
            dz_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            ds_req.start = 1'b1;
            ds_req.num   = nr_nxt.mag;
            ds_req.den   = den_r;
            state_nxt = ST_DIV;
          end
        end else begin
          rre_nxt = st_re[31:0];
          rim_nxt = st_im[31:0];
          ov_nxt  = ov_r | st_re[32] | st_im[32];
          if (cmd_r == CMD_POW && steps_r != EXP_W'(1)) begin
            steps_nxt = steps_r - EXP_W'(1);
            pa_nxt = st_re[31:0];
            pb_nxt = st_im[31:0];
            mi_nxt = '0;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (ds_rsp.done) begin
          sa = dpart_r ? ni_r : nr_r;
          sat_a = settle(sa.neg, {1'b0, ds_rsp.res});
          ov_nxt = ov_r | sat_a[32];
          if (!dpart_r) begin
            rre_nxt = sat_a[31:0];
            dpart_nxt = 1'b1;
            ds_req.start = 1'b1;
            ds_req.num   = ni_r.mag;
            ds_req.den   = den_r;
          end else begin
            rim_nxt = sat_a[31:0];
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQRT: begin
        if (ds_rsp.done) begin
          sat_a = settle(1'b0, {1'b0, ds_rsp.res});
          rre_nxt = sat_a[31:0];
          ov_nxt  = sat_a[32];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_nxt = '0;
        out_nxt.result_re = rre_r;
        out_nxt.result_im = rim_r;
        out_nxt.overflow  = ov_r;
        out_nxt.div_zero  = dz_r;
        case (cmd_r)
          CMD_ADD, CMD_SUB: begin
            wa = (cmd_r == CMD_ADD) ? 33'(op_r.first_re) + 33'(op_r.second_re)
                                    : 33'(op_r.first_re) - 33'(op_r.second_re);
            wb = (cmd_r == CMD_ADD) ? 33'(op_r.first_im) + 33'(op_r.second_im)
                                    : 33'(op_r.first_im) - 33'(op_r.second_im);
          end
          CMD_CONJ: begin
            wa = 33'(op_r.first_re);
            wb = -33'(op_r.first_im);
          end
          CMD_NEG: begin
            wa = -33'(op_r.first_re);
            wb = -33'(op_r.first_im);
          end
          default: begin
            wa = '0;
            wb = '0;
          end
        endcase
        // 33-bit results saturate when the top two bits differ
        sat_a = (wa[32] != wa[31]) ? {1'b1, wa[32] ? 32'h8000_0000 : 32'h7FFF_FFFF}
                                   : {1'b0, wa[31:0]};
        sat_b = (wb[32] != wb[31]) ? {1'b1, wb[32] ? 32'h8000_0000 : 32'h7FFF_FFFF}
                                   : {1'b0, wb[31:0]};
        if (cmd_r inside {CMD_ADD, CMD_SUB, CMD_CONJ, CMD_NEG}) begin
          out_nxt.result_re = sat_a[31:0];
          out_nxt.result_im = sat_b[31:0];
          out_nxt.overflow  = sat_a[32] | sat_b[32];
        end else if (cmd_r == CMD_EQ) begin
          out_nxt.equal_flag = (op_r.first_re == op_r.second_re) &&
                               (op_r.first_im == op_r.second_im);
        end
        ov_valid_nxt = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_valid_r || out_xfer) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ov_valid_r <= 1'b0;
      mul_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ov_valid_r <= ov_valid_nxt;
      mul_v_r    <= (state_r == ST_MUL);
    end
    if (in_xfer) begin
      op_r  <= in_data;
      cmd_r <= in_data.cmd;
    end
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    steps_r <= steps_nxt;
    mi_r    <= mi_nxt;
    ov_r    <= ov_nxt;
    dz_r    <= dz_nxt;
    dpart_r <= dpart_nxt;
    rre_r   <= rre_nxt;
    rim_r   <= rim_nxt;
    nr_r    <= nr_nxt;
    ni_r    <= ni_nxt;
    out_r   <= out_nxt;
    // capture product of the previous pass
    if (state_r == ST_MUL && mul_v_r) begin
      if (cmd_r == CMD_MAG) begin
        if (mi_r == 3'd7) prod_r[0] <= to_sm(mul_r);
      end else begin
        case (mi_r)
          3'd1: prod_r[0] <= to_sm(mul_r);
          3'd2: prod_r[1] <= to_sm(mul_r);
          3'd3: prod_r[2] <= to_sm(mul_r);
          3'd4: prod_r[3] <= to_sm(mul_r);
          3'd5: den_r <= 64'(mul_r);
          3'd6: den_r <= den_r + 64'(mul_r);
          default: ;
        endcase
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !out_valid) else $error("result ahead of work");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> out_valid) else $error("finish without result");
  a_dz_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |-> cmd_r == CMD_DIV) else $error("stray div flag");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// testbench: self-checking bench for complex_fixed_point_alu_unit
// depends on cfpa_pkg and the alu rtl; predicts every result and compares fields
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cfpa_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int EB = EXP_BITS_DEF;
  localparam int N_RANDOM = 1100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  complex_fixed_point_alu_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // pending operand items and the results they should give
  in_item_t  op_queue[$];
  out_item_t result_queue[$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_sent = 0;
  bit        quiet_phase = 0;   // no idling on either side near the end
  bit        hold_sender = 0;   // sender pauses until results drain
  bit        hold_receiver = 0; // receiver held off for a long stretch

  // wide signed values kept as sign and 66-bit magnitude
  typedef struct {
    bit         neg;
    bit [65:0]  mag;
  } wide_val_t;

  function automatic wide_val_t prod(logic signed [31:0] x, logic signed [31:0] y);
    wide_val_t w;
    longint p;
    p = longint'(x) * longint'(y);
    w.neg = p < 0;
    w.mag = w.neg ? 66'(-p) : 66'(p);
    return w;
  endfunction

  function automatic wide_val_t flip(wide_val_t a);
    if (a.mag != 0) a.neg = !a.neg;
    return a;
  endfunction

  function automatic wide_val_t wsum(wide_val_t a, wide_val_t b);
    wide_val_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg; r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg; r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg; r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  // clamp a sign/magnitude value into 32 bits
  function automatic logic signed [31:0] clamp_sm(bit neg, bit [65:0] mag, ref bit ov);
    if (neg) begin
      if (mag >= 66'h8000_0000) begin
        if (mag > 66'h8000_0000) ov = 1;
        return 32'sh8000_0000;
      end
      return -$signed({1'b0, mag[30:0]});
    end
    if (mag > 66'h7FFF_FFFF) begin
      ov = 1;
      return 32'sh7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_int(longint v, ref bit ov);
    if (v > 64'sd2147483647) begin ov = 1; return 32'sh7FFF_FFFF; end
    if (v < -64'sd2147483648) begin ov = 1; return 32'sh8000_0000; end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_fix(wide_val_t w, ref bit ov);
    bit [65:0] m;
    m = (w.mag + (66'd1 << (FB - 1))) >> FB;
    return clamp_sm(w.neg, m, ov);
  endfunction

  function automatic void cplx_mul(input logic signed [31:0] a, b, c, d,
                                   output logic signed [31:0] re, im, ref bit ov);
    re = round_fix(wsum(prod(a, c), flip(prod(b, d))), ov);
    im = round_fix(wsum(prod(a, d), prod(b, c)), ov);
  endfunction

  // rounded n * 2^FB / d by long division, saturating huge quotients
  function automatic bit [65:0] fix_quot(bit [65:0] n, bit [65:0] d);
    bit [65:0] q, r;
    q = n / d;
    r = n % d;
    if (q >= (66'd1 << 33)) return {66{1'b1}};
    for (int i = 0; i < FB + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic bit [65:0] int_sqrt(bit [65:0] v);
    bit [65:0] res, b;
    res = 0;
    b = 66'd1 << 64;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t predict_alu(in_item_t it);
    out_item_t o;
    bit ov;
    logic signed [31:0] a, b, c, d, re, im, tr, ti;
    bit [EB-1:0] n;
    wide_val_t nr, ni;
    bit [65:0] den;
    a = it.first_re; b = it.first_im; c = it.second_re; d = it.second_im;
    n = it.exponent[EB-1:0];
    ov = 0; re = 0; im = 0;
    o = '0;
    case (it.cmd)
      CMD_ADD: begin
        re = clamp_int(longint'(a) + longint'(c), ov);
        im = clamp_int(longint'(b) + longint'(d), ov);
      end
      CMD_SUB: begin
        re = clamp_int(longint'(a) - longint'(c), ov);
        im = clamp_int(longint'(b) - longint'(d), ov);
      end
      CMD_MUL: cplx_mul(a, b, c, d, re, im, ov);
      CMD_DIV: begin
        if (c == 0 && d == 0) begin
          o.div_zero = 1;
        end else begin
          den = prod(c, c).mag + prod(d, d).mag;
          nr = wsum(prod(a, c), prod(b, d));
          ni = wsum(prod(b, c), flip(prod(a, d)));
          re = clamp_sm(nr.neg, fix_quot(nr.mag, den), ov);
          im = clamp_sm(ni.neg, fix_quot(ni.mag, den), ov);
        end
      end
      CMD_POW: begin
        if (n == 0) begin
          re = 32'sd1 << FB;
        end else begin
          re = a; im = b;
          for (int k = 1; k < n; k++) begin
            cplx_mul(a, b, re, im, tr, ti, ov);
            re = tr; im = ti;
          end
        end
      end
      CMD_MAG: re = clamp_sm(0, int_sqrt(prod(a, a).mag + prod(b, b).mag), ov);
      CMD_CONJ: begin
        re = a;
        im = clamp_int(-longint'(b), ov);
      end
      CMD_NEG: begin
        re = clamp_int(-longint'(a), ov);
        im = clamp_int(-longint'(b), ov);
      end
      CMD_EQ: o.equal_flag = (a == c) && (b == d);
      default: ;
    endcase
    o.result_re = re;
    o.result_im = im;
    o.overflow  = ov;
    return o;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver: presents queued items, idles in random bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        result_queue.push_back(predict_alu(in_data));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        // previous transfer done (or none pending): pick what comes next
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 0;
        end else if (hold_sender || op_queue.size() == 0) begin
          in_valid <= 0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 8) - 1;
          in_valid <= 0;
        end else begin
          in_data  <= op_queue.pop_front();
          in_valid <= 1;
        end
      end
    end
  end

  // monitor: back-pressure and comparison against the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (result_queue.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          exp_r = result_queue.pop_front();
          if (out_data.result_re !== exp_r.result_re) begin
            $error("result_re expected %0d got %0d", exp_r.result_re, out_data.result_re);
            n_errors++;
          end
          if (out_data.result_im !== exp_r.result_im) begin
            $error("result_im expected %0d got %0d", exp_r.result_im, out_data.result_im);
            n_errors++;
          end
          if (out_data.equal_flag !== exp_r.equal_flag) begin
            $error("equal_flag expected %0b got %0b", exp_r.equal_flag, out_data.equal_flag);
            n_errors++;
          end
          if (out_data.div_zero !== exp_r.div_zero) begin
            $error("div_zero expected %0b got %0b", exp_r.div_zero, out_data.div_zero);
            n_errors++;
          end
          if (out_data.overflow !== exp_r.overflow) begin
            $error("overflow expected %0b got %0b", exp_r.overflow, out_data.overflow);
            n_errors++;
          end
        end
      end
      if (hold_receiver) begin
        out_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 8) - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;  // near unity
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(cmd_t op, logic signed [31:0] a, b, c, d,
                                         logic [7:0] e);
    in_item_t it;
    it.cmd = op; it.first_re = a; it.first_im = b;
    it.second_re = c; it.second_im = d; it.exponent = e;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.cmd = (($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8)));
    it.first_re = rand_part(); it.first_im = rand_part();
    it.second_re = rand_part(); it.second_im = rand_part();
    if ($urandom_range(0, 3) == 0) it.second_im = 0;   // real scalar form
    if (it.cmd == CMD_EQ && $urandom_range(0, 1)) begin
      it.second_re = it.first_re; it.second_im = it.first_im;
    end
    if (it.cmd == CMD_DIV && $urandom_range(0, 7) == 0) begin
      it.second_re = 0; it.second_im = 0;
    end
    // most powers are short, a few exercise the full exponent range
    it.exponent = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    return it;
  endfunction

  task automatic wait_drained();
    while (op_queue.size() != 0 || in_valid || result_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic wait_drained_results();
    while (result_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  initial begin
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, every operation, special cases
    op_queue.push_back(make_item(CMD_ADD, MAXV, MINV, MAXV, MINV, 0));
    op_queue.push_back(make_item(CMD_SUB, MINV, MAXV, MAXV, MINV, 8'hFF));
    op_queue.push_back(make_item(CMD_MUL, MAXV, MAXV, MINV, MINV, 0));
    op_queue.push_back(make_item(CMD_MUL, ONE, ONE, ONE >>> 1, -(ONE >>> 1), 0));
    op_queue.push_back(make_item(CMD_DIV, ONE, 0, 0, 0, 0));
    op_queue.push_back(make_item(CMD_DIV, MAXV, MINV, 1, 0, 0));
    op_queue.push_back(make_item(CMD_DIV, ONE, ONE, 3 * ONE, -ONE, 0));
    op_queue.push_back(make_item(CMD_POW, 12345, -6789, 0, 0, 0));
    op_queue.push_back(make_item(CMD_POW, ONE, ONE, 0, 0, 8'd5));
    op_queue.push_back(make_item(CMD_POW, 2 * ONE, 0, 0, 0, 8'hFF));
    op_queue.push_back(make_item(CMD_MAG, MINV, MINV, 0, 0, 0));
    op_queue.push_back(make_item(CMD_MAG, 3 * ONE, 4 * ONE, 0, 0, 0));
    op_queue.push_back(make_item(CMD_CONJ, MAXV, MINV, 0, 0, 0));
    op_queue.push_back(make_item(CMD_NEG, MINV, MAXV, 0, 0, 0));
    op_queue.push_back(make_item(CMD_EQ, -5, 7, -5, 7, 0));
    op_queue.push_back(make_item(CMD_EQ, -5, 7, -5, 8, 0));
    op_queue.push_back(make_item(cmd_t'(4'd15), MAXV, MAXV, MAXV, MAXV, 8'hFF));
    op_queue.push_back(make_item(cmd_t'(4'd9), -1, -1, -1, -1, 8'h80));
    wait_drained();

    // sender pause: part of a batch goes through, then wait for every result
    for (int i = 0; i < 200; i++) op_queue.push_back(rand_item());
    while (op_queue.size() > 100) @(posedge clk);
    hold_sender = 1;
    wait_drained_results();
    hold_sender = 0;

    // receiver held off while items keep coming, so the input stalls
    hold_receiver = 1;
    for (int i = 0; i < 300; i++) op_queue.push_back(rand_item());
    repeat (400) @(posedge clk);
    hold_receiver = 0;
    for (int i = 0; i < N_RANDOM - 500; i++) op_queue.push_back(rand_item());
    while (op_queue.size() > 60) @(posedge clk);
    quiet_phase = 1;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d transfers in, %0d results checked, all nine operations and",
             n_sent, n_results);
    $display("unused codes, with random idling, a long result stall and a drain pause");
    if (n_errors == 0 && result_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit: power items run exponent-1 complex multiply steps each
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== complex_fixed_point_alu_unit.f =====
rtl/core/cfpa_pkg.sv
rtl/core/cfpa_divsqrt.sv
rtl/core/complex_fixed_point_alu_unit.sv
test/testbench.sv
